// ----- rtl/qlqr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qlqr_pkg
// Shared constants, register codes and the natural-log table for the
// quartic-log plus quadratic ramp evaluator.
// ----------------------------------------------------------------------------
package qlqr_pkg;

	localparam int DATA_W    = 32;
	localparam int LN_N      = 256;               // table intervals, power of two
	localparam int LN_IDX_W  = $clog2(LN_N);
	localparam int CFG_IDX_W = 4;
	localparam int ACC_W     = 82;                // holds every Q.32 term sum exactly

	localparam logic [32:0] LN2_Q32 = 33'h0B17217F8;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOG_OFFSET     = 4'd0,
		REG_LOG_COEF_FOUR  = 4'd1,
		REG_LOG_COEF_THREE = 4'd2,
		REG_LOG_COEF_TWO   = 4'd3,
		REG_LOG_COEF_ONE   = 4'd4,
		REG_POLY_COEF_TWO  = 4'd5,
		REG_POLY_COEF_ONE  = 4'd6,
		REG_POLY_COEF_ZERO = 4'd7
	} reg_idx_t;

	typedef logic [31:0] ln_rom_t [0:LN_N];

	// log2 of a Q1.30 mantissa in [1,2], as a Q0.32 fraction, by repeated squaring
	function automatic logic [63:0] log2_frac(input logic [63:0] m_in);
		logic [63:0] m;
		logic [63:0] y;
		m = m_in;
		y = '0;
		if (m >= 64'h8000_0000) begin
			y = 64'h1_0000_0000;
		end else begin
			for (int i = 0; i < 32; i++) begin
				m = (m * m) >> 30;
				y = y << 1;
				if (m >= 64'h8000_0000) begin
					m = m >> 1;
					y = y | 64'd1;
				end
			end
		end
		return y;
	endfunction

	// ln(1 + i/N) in Q0.32 for every table point
	function automatic ln_rom_t ln_rom_init();
		ln_rom_t     t;
		logic [63:0] m;
		logic [63:0] p;
		for (int i = 0; i <= LN_N; i++) begin
			m    = ((64'(LN_N) + 64'(i)) << 30) / LN_N;
			p    = log2_frac(m) * 64'(LN2_Q32) + 64'h8000_0000;
			t[i] = p[63:32];
		end
		return t;
	endfunction

	localparam ln_rom_t LN_ROM = ln_rom_init();

endpackage
`default_nettype wire

// ----- rtl/qlqr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qlqr channel interfaces
// Sample, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface qlqr_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] time_sample;
	modport source (output valid, output time_sample, input ready);
	modport sink   (input valid, input time_sample, output ready);
endinterface

interface qlqr_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] flux_value;
	logic               saturated_flag;
	modport source (output valid, output flux_value, output saturated_flag, input ready);
	modport sink   (input valid, input flux_value, input saturated_flag, output ready);
endinterface

interface qlqr_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/qlqr_ln.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qlqr_ln
// Four-stage natural log of a positive 32-bit Q16.16 value: normalize,
// table read, interpolation multiply, exponent fold and round to Q8.16.
// ----------------------------------------------------------------------------
module qlqr_ln
	import qlqr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic        [31:0] d,
	output logic signed      [23:0] l
);

	logic [4:0]                k_s1, k_s2, k_s3;
	logic [LN_IDX_W-1:0]       idx_s1;
	logic [29:0]               w_s1, w_s2;
	logic [31:0]               lo_s2, lo_s3;
	logic [31:0]               diff_s2;
	logic [31:0]               ip_s3;

	logic [4:0]                k_c;
	logic [31:0]               norm_c;
	logic [29:0]               frac_c;
	logic [LN_IDX_W:0]         idx_nx_c;
	logic [61:0]               prod_c;
	logic signed [5:0]         e_c;
	logic signed [39:0]        lq_c;
	logic signed [39:0]        lr_c;

	// leading one search and normalization
	always_comb begin
		k_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (d[i]) begin
				k_c = 5'(i);
			end
		end
		norm_c = d << (5'd31 - k_c);
		frac_c = norm_c[30:1];
	end

	// table neighbor index
	assign idx_nx_c = {1'b0, idx_s1} + (LN_IDX_W+1)'(1);

	// interpolation product
	assign prod_c = 62'(diff_s2) * 62'(w_s2);

	// fold exponent and round to Q8.16
	always_comb begin
		e_c  = $signed({1'b0, k_s3}) - 6'sd16;
		lq_c = 40'(e_c) * 40'($signed(LN2_Q32)) + 40'(lo_s3) + 40'(ip_s3);
		lr_c = lq_c + 40'sd32768;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1    <= k_c;
			idx_s1  <= frac_c[29 -: LN_IDX_W];
			w_s1    <= {frac_c[29-LN_IDX_W:0], LN_IDX_W'(0)};
			k_s2    <= k_s1;
			w_s2    <= w_s1;
			lo_s2   <= LN_ROM[idx_s1];
			diff_s2 <= LN_ROM[idx_nx_c] - LN_ROM[idx_s1];
			k_s3    <= k_s2;
			lo_s3   <= lo_s2;
			ip_s3   <= prod_c[61:30];
			l       <= lr_c[39:16];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/quartic_log_quadratic_ramp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quartic_log_quadratic_ramp
// Ramp model: quartic in ln(x - offset) plus quadratic in x, Q16.16.
// ----------------------------------------------------------------------------
// The block accepts one sample request per clock while the result side is not
// stalled, and returns one result per sample, in order, from the output
// register. Nine register stages plus the output register carry valid bits with
// the data; the log path (normalize, table, interpolation, fold) and the chain
// of power multiplies set that depth. Backpressure on the result channel
// freezes the whole pipeline, and the sample channel is ready whenever the
// output register is empty or being taken. Samples at or below log_offset give
// exactly 1.0. Coefficients are written through the configuration channel,
// which is always ready; write them only while no sample is in flight.
// ----------------------------------------------------------------------------
module quartic_log_quadratic_ramp
	import qlqr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	qlqr_cfg_if.sink     cfg,
	qlqr_sample_if.sink  sample,
	qlqr_result_if.source result
);

	// configuration registers
	logic signed [31:0] offset_q, c4_q, c3_q, c2_q, c1_q, p2_q, p1_q, p0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0; c4_q <= '0; c3_q <= '0; c2_q <= '0;
			c1_q     <= '0; p2_q <= '0; p1_q <= '0; p0_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LOG_OFFSET:     offset_q <= cfg.data;
				REG_LOG_COEF_FOUR:  c4_q     <= cfg.data;
				REG_LOG_COEF_THREE: c3_q     <= cfg.data;
				REG_LOG_COEF_TWO:   c2_q     <= cfg.data;
				REG_LOG_COEF_ONE:   c1_q     <= cfg.data;
				REG_POLY_COEF_TWO:  p2_q     <= cfg.data;
				REG_POLY_COEF_ONE:  p1_q     <= cfg.data;
				REG_POLY_COEF_ZERO: p0_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// pipeline control
	logic en;
	logic res_valid_q;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic le_s1, le_s2, le_s3, le_s4, le_s5, le_s6, le_s7, le_s8, le_s9;

	assign en           = !res_valid_q || result.ready;
	assign sample.ready = en;

	// payload
	logic        [31:0]      d_s1;
	logic signed [31:0]      x_s1;
	logic signed [63:0]      xx_s1;
	logic signed [55:0]      x2lo_s2;
	logic signed [56:0]      x2hi_s2;
	logic signed [63:0]      xp1_s2;
	logic signed [ACC_W-1:0] poly_s3, poly_s4, poly_s5, poly_s6, poly_s7;
	logic signed [23:0]      l_s5;
	logic signed [23:0]      l_s6;
	logic signed [47:0]      ll_s6;
	logic signed [55:0]      lc1_s6, lc1_s7;
	logic signed [48:0]      l2l_s7;
	logic signed [49:0]      l2l2_s7;
	logic signed [56:0]      l2c2_s7;
	logic signed [59:0]      l3c3_s8;
	logic signed [63:0]      l4c4_s8;
	logic signed [ACC_W-1:0] part_s8;
	logic signed [ACC_W-1:0] sum_s9;

	logic signed [32:0]      diff_c;
	logic        [63:0]      x2r_c;
	logic        [46:0]      x2_c;
	logic signed [47:0]      l2r_c;
	logic signed [24:0]      l2_c;
	logic signed [48:0]      l3r_c;
	logic signed [49:0]      l4r_c;
	logic signed [27:0]      l3_c;
	logic signed [31:0]      l4_c;
	logic                    in_range_c;

	assign diff_c = 33'(sample.time_sample) - 33'(offset_q);

	// log path
	qlqr_ln u_ln (
		.clk (clk),
		.en  (en),
		.d   (d_s1),
		.l   (l_s5)
	);

	// rounding steps
	always_comb begin
		x2r_c = $unsigned(xx_s1) + 64'd32768;
		x2_c  = x2r_c[62:16];
		l2r_c = ll_s6 + 48'sd32768;
		l2_c  = l2r_c[40:16];
		l3r_c = l2l_s7 + 49'sd32768;
		l3_c  = l3r_c[43:16];
		l4r_c = l2l2_s7 + 50'sd32768;
		l4_c  = l4r_c[47:16];
	end

	// result fits Q16.16 when the bits above it are all sign
	assign in_range_c = (sum_s9[ACC_W-1:47] == '0) || (sum_s9[ACC_W-1:47] == '1);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
			vld_s4 <= 1'b0; vld_s5 <= 1'b0; vld_s6 <= 1'b0;
			vld_s7 <= 1'b0; vld_s8 <= 1'b0; vld_s9 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample.valid;
			vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
			vld_s8 <= vld_s7; vld_s9 <= vld_s8;
			res_valid_q <= vld_s9;
		end
	end

	// data stages
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: offset, at-or-below check, x squared
			d_s1  <= diff_c[31:0];
			le_s1 <= (sample.time_sample <= offset_q);
			x_s1  <= sample.time_sample;
			xx_s1 <= 64'(sample.time_sample) * 64'(sample.time_sample);
			// stage 2: round x^2, split x^2 * p2, x * p1
			le_s2   <= le_s1;
			x2lo_s2 <= 56'($signed({1'b0, x2_c[22:0]})) * 56'(p2_q);
			x2hi_s2 <= 57'($signed({1'b0, x2_c[46:23]})) * 57'(p2_q);
			xp1_s2  <= 64'(x_s1) * 64'(p1_q);
			// stage 3: quadratic part plus rounding constant
			le_s3   <= le_s2;
			poly_s3 <= (ACC_W'(x2hi_s2) <<< 23) + ACC_W'(x2lo_s2) + ACC_W'(xp1_s2)
				+ (ACC_W'(p0_q) <<< 16) + ACC_W'(32768);
			// stages 4, 5: wait for the log
			le_s4 <= le_s3; poly_s4 <= poly_s3;
			le_s5 <= le_s4; poly_s5 <= poly_s4;
			// stage 6: L^2 and c1*L
			le_s6   <= le_s5;
			poly_s6 <= poly_s5;
			l_s6    <= l_s5;
			ll_s6   <= 48'(l_s5) * 48'(l_s5);
			lc1_s6  <= 56'(l_s5) * 56'(c1_q);
			// stage 7: round L^2, then L^3, L^4 and c2*L^2
			le_s7   <= le_s6;
			poly_s7 <= poly_s6;
			lc1_s7  <= lc1_s6;
			l2l_s7  <= 49'(l2_c) * 49'(l_s6);
			l2l2_s7 <= 50'(l2_c) * 50'(l2_c);
			l2c2_s7 <= 57'(l2_c) * 57'(c2_q);
			// stage 8: round L^3, L^4 and weigh them
			le_s8   <= le_s7;
			l3c3_s8 <= 60'(l3_c) * 60'(c3_q);
			l4c4_s8 <= 64'(l4_c) * 64'(c4_q);
			part_s8 <= poly_s7 + ACC_W'(lc1_s7) + ACC_W'(l2c2_s7);
			// stage 9: full sum
			le_s9  <= le_s8;
			sum_s9 <= part_s8 + ACC_W'(l3c3_s8) + ACC_W'(l4c4_s8);
			// output: special case, saturation
			priority if (le_s9) begin
				result.flux_value     <= 32'sh0001_0000;
				result.saturated_flag <= 1'b0;
			end else if (in_range_c) begin
				result.flux_value     <= sum_s9[47:16];
				result.saturated_flag <= 1'b0;
			end else begin
				result.flux_value     <= sum_s9[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
				result.saturated_flag <= 1'b1;
			end
		end
	end

	assign result.valid = res_valid_q;

endmodule
`default_nettype wire

// ----- tb/quartic_log_quadratic_ramp_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quartic_log_quadratic_ramp_tb
// Self-checking bench for the ramp evaluator. A local fixed-point predictor
// (own log table, interpolation, power chain and wide accumulator) computes
// each expected flux value. Directed cases cover the offset boundary, sample
// extremes, saturation both ways and writes to unused register indexes.
// The random phases then sweep coefficient sets under bursty requests and
// result-side stalls.
// ----------------------------------------------------------------------------
module quartic_log_quadratic_ramp_tb;
	import qlqr_pkg::*;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          DRAIN_WAIT  = 16;
	localparam logic [3:0]  REG_SPARE_A = 4'd9;
	localparam logic [3:0]  REG_SPARE_B = 4'd15;
	localparam logic [63:0] LN2_FIX     = 64'hB17217F8;
	localparam logic signed [127:0] SUM_TOP = 128'sd1 <<< 47;

	typedef struct {
		logic [31:0] flux;
		logic        sat;
	} flux_t;

	logic clk;
	logic arst_n;

	qlqr_cfg_if    cfg_ch ();
	qlqr_sample_if sample_ch ();
	qlqr_result_if result_ch ();

	quartic_log_quadratic_ramp u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (sample_ch),
		.result (result_ch)
	);

	logic [63:0]        ln_table [0:LN_N];
	logic signed [31:0] coef_shadow [0:7];
	flux_t              flux_expect_q [$];
	int                 fail_count;
	int                 cycle_count;
	int                 burst_left;
	bit                 gaps_on;
	int                 stall_mode;
	int                 stall_phase;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("quartic_log_quadratic_ramp regression: fail");
			$finish;
		end
	end

	// result-side stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_phase     <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 13;
			case (stall_mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= ($urandom_range(0, 9) < 7);
				default: result_ch.ready <= (stall_phase > 5);
			endcase
		end
	end

	// result checker; values are stable at the falling edge before acceptance
	always @(negedge clk) begin
		flux_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (flux_expect_q.size() == 0) begin
				$error("unexpected result flux_value=%h", result_ch.flux_value);
				fail_count++;
			end else begin
				want = flux_expect_q.pop_front();
				if (result_ch.flux_value !== want.flux) begin
					$error("flux_value expected %h actual %h", want.flux,
						result_ch.flux_value);
					fail_count++;
				end
				if (result_ch.saturated_flag !== want.sat) begin
					$error("saturated_flag expected %b actual %b", want.sat,
						result_ch.saturated_flag);
					fail_count++;
				end
			end
		end
	end

	// log2 of a Q1.30 mantissa as Q0.32, by squaring
	function automatic logic [63:0] mant_log2(input logic [63:0] m_in);
		logic [63:0] m;
		logic [63:0] y;
		m = m_in;
		y = '0;
		if (m >= 64'h8000_0000) return 64'h1_0000_0000;
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 30;
			y = y << 1;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				y = y | 64'd1;
			end
		end
		return y;
	endfunction

	// ln(d) in Q.32, d a positive raw Q16.16 difference
	function automatic longint ln_of_diff(input logic [63:0] d);
		int          k;
		logic [63:0] frac;
		logic [63:0] pos;
		logic [63:0] idx;
		logic [63:0] w;
		longint      lo;
		longint      hi;
		k = 31;
		while (k > 0 && !d[k]) k--;
		if (k >= 30) frac = (d >> (k - 30)) - (64'd1 << 30);
		else         frac = (d << (30 - k)) - (64'd1 << 30);
		pos = frac * LN_N;
		idx = pos >> 30;
		w   = pos & 64'h3FFF_FFFF;
		if (idx >= LN_N) idx = LN_N - 1;
		lo = longint'(ln_table[idx]);
		hi = longint'(ln_table[idx + 1]);
		return longint'(k - 16) * longint'(LN2_FIX) + lo + (((hi - lo) * longint'(w)) >>> 30);
	endfunction

	function automatic longint round_q16(input longint v);
		return (v + 32768) >>> 16;
	endfunction

	// expected result for one sample under the current shadow registers
	function automatic flux_t predict_flux(input logic signed [31:0] x);
		flux_t              r;
		longint             xl;
		longint             lg;
		longint             lg2;
		longint             lg3;
		longint             lg4;
		logic [63:0]        sq;
		logic signed [127:0] t4, t3, t2, t1, tx2, tx, c4, c3, c2, c1, p2, p1, p0;
		logic signed [127:0] sum;
		xl = x;
		if (x <= coef_shadow[REG_LOG_OFFSET]) begin
			r.flux = 32'h0001_0000;
			r.sat  = 1'b0;
			return r;
		end
		lg  = round_q16(ln_of_diff(64'(xl - longint'(coef_shadow[REG_LOG_OFFSET]))));
		lg2 = round_q16(lg * lg);
		lg3 = round_q16(lg2 * lg);
		lg4 = round_q16(lg2 * lg2);
		sq  = (64'(xl * xl) + 64'd32768) >> 16;
		t4 = lg4; t3 = lg3; t2 = lg2; t1 = lg;
		tx2 = $signed({64'd0, sq});
		tx  = xl;
		c4 = coef_shadow[REG_LOG_COEF_FOUR];
		c3 = coef_shadow[REG_LOG_COEF_THREE];
		c2 = coef_shadow[REG_LOG_COEF_TWO];
		c1 = coef_shadow[REG_LOG_COEF_ONE];
		p2 = coef_shadow[REG_POLY_COEF_TWO];
		p1 = coef_shadow[REG_POLY_COEF_ONE];
		p0 = coef_shadow[REG_POLY_COEF_ZERO];
		sum = t4 * c4 + t3 * c3 + t2 * c2 + t1 * c1 + tx2 * p2 + tx * p1
			+ p0 * 128'sd65536 + 128'sd32768;
		if (sum >= SUM_TOP) begin
			r.flux = 32'h7FFF_FFFF;
			r.sat  = 1'b1;
		end else if (sum < -SUM_TOP) begin
			r.flux = 32'h8000_0000;
			r.sat  = 1'b1;
		end else begin
			r.flux = sum[47:16];
			r.sat  = 1'b0;
		end
		return r;
	endfunction

	// one sample request, with bursts and gaps on the sender side
	task automatic send_sample(input logic [31:0] x);
		bit got;
		if (gaps_on && burst_left == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.time_sample <= x;
		do begin
			@(negedge clk);
			got = sample_ch.ready;
			if (got) flux_expect_q.push_back(predict_flux(x));
			@(posedge clk);
		end while (!got);
		if (burst_left > 0) burst_left--;
	endtask

	// wait until every expected result is back, then let the pipe empty
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (flux_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] value);
		bit got;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do begin
			@(negedge clk);
			got = cfg_ch.ready;
			@(posedge clk);
		end while (!got);
		cfg_ch.valid <= 1'b0;
		if (idx <= REG_POLY_COEF_ZERO) coef_shadow[idx] = value;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] v [0:7]);
		for (int i = 0; i < 8; i++) write_reg(4'(i), v[i]);
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return 32'd0;
			2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h40000))
			                               : -32'($urandom_range(0, 32'h40000));
			3: return $urandom();
			default: return 32'($signed($urandom()) >>> $urandom_range(4, 20));
		endcase
	endfunction

	// samples clustered around the offset plus full-range noise
	function automatic logic [31:0] rand_sample();
		longint off;
		longint v;
		off = coef_shadow[REG_LOG_OFFSET];
		case ($urandom_range(0, 5))
			0: v = off - longint'($urandom_range(0, 32'h20000));
			1: v = off + longint'($urandom_range(1, 64));
			2: v = off + longint'($urandom_range(1, 32'h100000));
			3: v = off + (longint'(1) << $urandom_range(0, 31));
			default: v = longint'($signed($urandom()));
		endcase
		if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) v = -64'sh8000_0000;
		return v[31:0];
	endfunction

	// boundary and extreme samples under the current registers
	task automatic send_edges();
		logic [31:0] off;
		off = coef_shadow[REG_LOG_OFFSET];
		send_sample(32'h0000_0000);
		send_sample(32'h0000_0001);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h0001_0000);
		send_sample(off);
		if (off != 32'h7FFF_FFFF) send_sample(off + 32'd1);
		if (off != 32'h8000_0000) send_sample(off - 32'd1);
	endtask

	// registers at reset: everything zero, so above-offset gives zero
	task automatic test_reset_values();
		stall_mode = 0;
		gaps_on    = 0;
		send_edges();
		drain();
	endtask

	// writes to unused indexes must leave the registers alone
	task automatic test_spare_index();
		write_reg(REG_SPARE_A, 32'h7FFF_FFFF);
		write_reg(REG_SPARE_B, 32'hA5A5_5A5A);
		send_sample(32'h0003_0000);
		send_sample(32'h8000_0000);
		drain();
	endtask

	// a moderate fit with the offset just off zero, every power in play
	task automatic test_directed_fit();
		logic [31:0] v [0:7];
		v = '{32'hFFFF_8000, 32'h0000_0100, 32'hFFFF_F000, 32'h0002_0000,
		      32'h0001_8000, 32'h0000_0001, 32'hFFFF_C000, 32'h0001_0000};
		write_all(v);
		stall_mode = 2;
		send_edges();
		for (int k = 0; k < 32; k += 5) send_sample(32'hFFFF_8000 + (32'd1 << k));
		drain();
	endtask

	// saturation both ways, and the offset at each extreme
	task automatic test_saturation();
		logic [31:0] v [0:7];
		v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
		      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		write_all(v);
		send_edges();
		drain();
		v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		write_all(v);
		send_edges();
		drain();
		write_reg(REG_LOG_OFFSET, 32'h7FFF_FFFF);
		send_edges();
		drain();
	endtask

	// random coefficient sets with random samples and idling
	task automatic test_random();
		logic [31:0] v [0:7];
		for (int s = 0; s < 15; s++) begin
			for (int i = 0; i < 8; i++) v[i] = rand_coef();
			write_all(v);
			stall_mode = $urandom_range(0, 2);
			gaps_on    = (s % 4) != 0;
			burst_left = 0;
			for (int n = 0; n < 108; n++) send_sample(rand_sample());
			drain();
		end
	endtask

	initial begin
		for (int i = 0; i <= LN_N; i++)
			ln_table[i] = (mant_log2(((64'(LN_N) + 64'(i)) << 30) / LN_N) * LN2_FIX
				+ 64'h8000_0000) >> 32;
		for (int i = 0; i < 8; i++) coef_shadow[i] = '0;
		burst_left            = 0;
		gaps_on               = 0;
		stall_mode            = 0;
		arst_n                = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = '0;
		cfg_ch.data           = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.time_sample = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_spare_index();
		test_directed_fit();
		test_saturation();
		test_random();

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0) begin
			$display("quartic_log_quadratic_ramp regression: pass");
		end else begin
			$display("quartic_log_quadratic_ramp regression: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/qlqr_pkg.sv
rtl/qlqr_if.sv
rtl/qlqr_ln.sv
rtl/quartic_log_quadratic_ramp.sv
tb/quartic_log_quadratic_ramp_tb.sv
